### rtl/rdq_pkg.sv
package rdq_pkg;

    // Widths of the item fields.
    localparam int unsigned MODE_W       = 3;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned OUT_COUNT_W  = 7;
    localparam int unsigned STATUS_W     = 2;

    // Default ring depth.
    localparam int unsigned DEFAULT_DEPTH = 64;

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REVERSE    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd5;

    // Status codes carried in the result.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

    // Value shown for both ends of an empty deque.
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] push_value;
    } rdq_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
        logic [OUT_COUNT_W-1:0]   count;
        logic                     is_empty;
        logic [STATUS_W-1:0]      status;
    } rdq_out_t;

endpackage

### rtl/reversible_deque_top.sv
// Reversible double-ended queue of signed 32-bit words.
//
// The input channel (s_valid, s_ready, s_data) carries one operation per
// transfer: push back, push front, pop back, pop front, reverse or peek.
// Every accepted operation produces exactly one result transfer on the
// output channel (m_valid, m_ready, m_data) holding the logical front and
// back words after the operation (-1 when empty), the element count, an
// empty flag and a status code.
//
// The deque state (head pointer, count, reverse flag) is updated at the
// accepting edge, where the slot memory is also written and read at the two
// new end slots. The read stage then formats the result into the output
// register, which drives m_valid, and the result transfers when m_ready is
// high. One operation is accepted every cycle while results keep draining.
//
// When the receiver stalls, the output register holds its result and one
// more operation can be taken into the read stage; after that s_ready
// drops until the output drains. Reset clears the pointers, the count,
// the reverse flag and both valid flags; slot contents need no clearing.
module reversible_deque_top #(
    parameter int unsigned DEPTH = rdq_pkg::DEFAULT_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rdq_pkg::rdq_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output rdq_pkg::rdq_out_t m_data
);
    import rdq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // Slot storage; only occupied slots are ever shown, so no clearing.
    logic [WORD_W-1:0] mem [DEPTH];

    // Deque state.
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;

    // Read stage: memory read data plus what is needed to format the result.
    logic                 b_valid_reg;
    logic [WORD_W-1:0]    b_rd_first_reg;
    logic [WORD_W-1:0]    b_rd_last_reg;
    logic                 b_fwd_first_reg;
    logic                 b_fwd_last_reg;
    logic [WORD_W-1:0]    b_wdata_reg;
    logic                 b_rev_reg;
    logic [CW-1:0]        b_count_reg;
    logic [STATUS_W-1:0]  b_status_reg;

    // Output register.
    logic     m_valid_reg;
    rdq_out_t m_data_reg, m_data_next;

    logic accept;
    logic b_advance;

    // Operation decode and ring arithmetic.
    logic                push_first, push_last, pop_first, pop_last;
    logic                is_full, is_zero;
    logic [STATUS_W-1:0] status_next;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [AW:0]         sum_tail;
    logic [AW-1:0]       tail_slot;
    logic [AW-1:0]       head_prev, head_succ;
    logic [AW:0]         sum_end;
    logic [AW-1:0]       end_slot;
    logic [AW-1:0]       rd_first_addr, rd_last_addr;

    // Formatting of the read stage.
    logic [WORD_W-1:0] first_word, last_word;

    assign b_advance = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !b_valid_reg || b_advance;
    assign accept    = s_valid && s_ready;

    always_comb begin
        push_first = 1'b0;
        push_last  = 1'b0;
        pop_first  = 1'b0;
        pop_last   = 1'b0;
        rev_next   = rev_reg;
        unique case (s_data.mode)
            MODE_PUSH_BACK: begin
                push_first = rev_reg;
                push_last  = !rev_reg;
            end
            MODE_PUSH_FRONT: begin
                push_first = !rev_reg;
                push_last  = rev_reg;
            end
            MODE_POP_BACK: begin
                pop_first = rev_reg;
                pop_last  = !rev_reg;
            end
            MODE_POP_FRONT: begin
                pop_first = !rev_reg;
                pop_last  = rev_reg;
            end
            MODE_REVERSE: begin
                rev_next = !rev_reg;
            end
            default: begin
                // Peek and the unused codes leave the deque alone.
            end
        endcase
    end

    always_comb begin
        is_full   = (count_reg == CW'(DEPTH));
        is_zero   = (count_reg == '0);

        // Slot just past the physical last element.
        sum_tail  = {1'b0, head_reg} + (AW+1)'(count_reg);
        tail_slot = (sum_tail >= (AW+1)'(DEPTH)) ? AW'(sum_tail - (AW+1)'(DEPTH))
                                                  : sum_tail[AW-1:0];
        head_prev = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
        head_succ = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

        head_next   = head_reg;
        count_next  = count_reg;
        status_next = STATUS_OK;
        wr_en       = 1'b0;
        wr_addr     = tail_slot;

        if (push_first || push_last) begin
            if (is_full) begin
                status_next = STATUS_PUSH_FULL;
            end else begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
                if (push_first) begin
                    head_next = head_prev;
                    wr_addr   = head_prev;
                end
            end
        end else if (pop_first || pop_last) begin
            if (is_zero) begin
                status_next = STATUS_POP_EMPTY;
            end else begin
                count_next = count_reg - 1'b1;
                if (pop_first) begin
                    head_next = head_succ;
                end
            end
        end

        // New end slots; the last one only matters when the deque is not empty.
        rd_first_addr = head_next;
        sum_end       = {1'b0, head_next} + (AW+1)'(count_next);
        end_slot      = (sum_end >= (AW+1)'(DEPTH)) ? AW'(sum_end - (AW+1)'(DEPTH))
                                                     : sum_end[AW-1:0];
        rd_last_addr  = (end_slot == '0) ? AW'(DEPTH - 1) : end_slot - 1'b1;
    end

    // Slot memory: one write port and two registered read ports. A read of
    // the slot written in the same cycle returns old data, so the read stage
    // takes the pushed word instead through the forward flags.
    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            mem[wr_addr] <= s_data.push_value;
        end
        if (accept) begin
            b_rd_first_reg <= mem[rd_first_addr];
            b_rd_last_reg  <= mem[rd_last_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end else if (accept) begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (accept) begin
            b_valid_reg <= 1'b1;
        end else if (b_advance) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_fwd_first_reg <= wr_en && (wr_addr == rd_first_addr);
            b_fwd_last_reg  <= wr_en && (wr_addr == rd_last_addr);
            b_wdata_reg     <= s_data.push_value;
            b_rev_reg       <= rev_next;
            b_count_reg     <= count_next;
            b_status_reg    <= status_next;
        end
    end

    // Map the physical ends onto the logical front and back.
    always_comb begin
        first_word = b_fwd_first_reg ? b_wdata_reg : b_rd_first_reg;
        last_word  = b_fwd_last_reg ? b_wdata_reg : b_rd_last_reg;

        m_data_next.count    = OUT_COUNT_W'(b_count_reg);
        m_data_next.is_empty = (b_count_reg == '0);
        m_data_next.status   = b_status_reg;
        if (b_count_reg == '0) begin
            m_data_next.front_value = EMPTY_WORD;
            m_data_next.back_value  = EMPTY_WORD;
        end else if (b_rev_reg) begin
            m_data_next.front_value = last_word;
            m_data_next.back_value  = first_word;
        end else begin
            m_data_next.front_value = first_word;
            m_data_next.back_value  = last_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/rdq_checker.sv
module rdq_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input rdq_pkg::rdq_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input rdq_pkg::rdq_out_t m_data
);
    import rdq_pkg::*;

    // A stalled result keeps its content.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // The output comes up empty after reset.
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // An empty deque shows -1 at both ends.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_empty) |->
            (m_data.front_value == EMPTY_WORD && m_data.back_value == EMPTY_WORD))
        else $error("empty deque shows a stored word");

    // An ignored pop leaves an empty deque; a dropped push leaves a non-empty one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_POP_EMPTY) |-> m_data.is_empty)
        else $error("pop flagged as empty on a non-empty deque");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_PUSH_FULL) |-> !m_data.is_empty)
        else $error("push flagged as full on an empty deque");

endmodule

bind reversible_deque_top rdq_checker u_rdq_checker (.*);
